// File: rtl/oale_pkg.sv
// Shared types and constants of the ordered array list engine.
package oale_pkg;

  localparam int ValW     = 32;
  localparam int ActW     = 3;
  localparam int StatW    = 2;
  localparam int CntOutW  = 5;

  // Action codes as they arrive on the input channel.
  localparam logic [ActW-1:0] ACT_INS_ORD   = 3'd0;
  localparam logic [ActW-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ActW-1:0] ACT_INS_FRONT = 3'd2;
  localparam logic [ActW-1:0] ACT_REM_FIRST = 3'd3;
  localparam logic [ActW-1:0] ACT_REM_LAST  = 3'd4;
  localparam logic [ActW-1:0] ACT_REM_VAL   = 3'd5;

  typedef enum logic [2:0] {
    OP_INS_ORD,
    OP_INS_BACK,
    OP_INS_FRONT,
    OP_REM_FIRST,
    OP_REM_LAST,
    OP_REM_VAL,
    OP_NOP
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UP_W,
    BK_PUT,
    BK_SRCH_W,
    BK_DN_W
  } back_state_e;

  // One classified transaction as it waits in the queue.
  typedef struct packed {
    op_e                     op;
    logic signed [ValW-1:0]  value;
  } op_t;

endpackage

// File: rtl/ordered_array_list_engine_core.sv
// Top level of the ordered array list engine: front queue plus RAM-based back end.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+------------------------
//   in      | input     | in_valid_i / in_ready_o    | action_i, value_i
//   out     | output    | out_valid_o / out_ready_i  | status_o, entry_count_o
//
// Insert back, remove last, refused or unused actions, inserts into an empty list and
// removal from the front of a one-entry list finish straight from idle; other inserts
// move entries up one at a time, and removals by value scan entries and, like removals
// from the front, move entries down one at a time, since the RAM reads one word a cycle.
// Reset clears the count, the queue and the result valid flag; the RAM is not cleared.
// While a result waits, the two-entry queue still takes transactions; the back end starts
// the next action only once that result has been taken.
module ordered_array_list_engine_core
  import oale_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ActW-1:0]         action_i,
  input  logic signed [ValW-1:0]  value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [StatW-1:0]        status_o,
  output logic [CntOutW-1:0]      entry_count_o
);

  // Classified transactions pass from the front queue to the back sequencer.
  logic op_valid;
  logic op_ready;
  op_t  op;

  oale_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .value_i    (value_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  // The back end owns the entry RAM, the count and the result register.
  oale_back #(
    .Depth (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (op_valid),
    .op_ready_o    (op_ready),
    .op_i          (op),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// File: rtl/oale_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oale_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/oale_front.sv
// Front end: accepts input transactions, classifies the action, and queues them.
module oale_front
  import oale_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ActW-1:0]         action_i,
  input  logic signed [ValW-1:0]  value_i,
  output logic                    op_valid_o,
  input  logic                    op_ready_i,
  output op_t                     op_o
);

  op_t        slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;
  op_t        cls;

  always_comb begin
    cls.value = value_i;
    case (action_i)
      ACT_INS_ORD:   cls.op = OP_INS_ORD;
      ACT_INS_BACK:  cls.op = OP_INS_BACK;
      ACT_INS_FRONT: cls.op = OP_INS_FRONT;
      ACT_REM_FIRST: cls.op = OP_REM_FIRST;
      ACT_REM_LAST:  cls.op = OP_REM_LAST;
      ACT_REM_VAL:   cls.op = OP_REM_VAL;
      default:       cls.op = OP_NOP;
    endcase
  end

  assign in_ready_o = (fill_q != 2'd2);
  assign op_valid_o = (fill_q != 2'd0);
  assign op_o       = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = op_valid_o && op_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// File: rtl/oale_back.sv
// Back end: sequencer that carries out list actions on the entry RAM and holds the result.
module oale_back
  import oale_pkg::*;
#(
  parameter int Depth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  output logic                op_ready_o,
  input  op_t                 op_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatW-1:0]    status_o,
  output logic [CntOutW-1:0]  entry_count_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  back_state_e            state_q, state_d;
  op_e                    op_q, op_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  status_e                res_status_q, res_status_d;
  logic [CW-1:0]          res_count_q, res_count_d;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [ValW-1:0]        ram_wdata, ram_rdata;

  logic [CW-1:0]          cnt_m1, cnt_p1, idx_m1, idx_m2, idx_p1, idx_p2;
  logic [CW+CntOutW-1:0]  cnt_ext;
  logic                   shift_up;

  assign cnt_m1 = count_q - CW'(1);
  assign cnt_p1 = count_q + CW'(1);
  assign idx_m1 = idx_q - CW'(1);
  assign idx_m2 = idx_q - CW'(2);
  assign idx_p1 = idx_q + CW'(1);
  assign idx_p2 = idx_q + CW'(2);

  assign shift_up = (op_q == OP_INS_FRONT) || ($signed(ram_rdata) > val_q);

  oale_ram #(
    .Width (ValW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    val_d        = val_q;
    idx_d        = idx_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    op_ready_o   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = val_q;
    ram_raddr    = '0;

    case (state_q)
      BK_IDLE: begin
        if (op_valid_i && !out_valid_q) begin
          op_ready_o   = 1'b1;
          op_d         = op_i.op;
          val_d        = op_i.value;
          out_valid_d  = 1'b1;
          res_status_d = STAT_OK;
          res_count_d  = count_q;
          case (op_i.op)
            OP_INS_ORD, OP_INS_BACK, OP_INS_FRONT: begin
              if (count_q == CW'(Depth)) begin
                res_status_d = STAT_FULL;
              end else if (op_i.op == OP_INS_BACK || count_q == '0) begin
                ram_we      = 1'b1;
                ram_waddr   = count_q[AW-1:0];
                ram_wdata   = op_i.value;
                count_d     = cnt_p1;
                res_count_d = cnt_p1;
              end else begin
                out_valid_d = 1'b0;
                ram_raddr   = cnt_m1[AW-1:0];
                idx_d       = count_q;
                state_d     = BK_UP_W;
              end
            end
            OP_REM_FIRST, OP_REM_LAST, OP_REM_VAL: begin
              if (count_q == '0) begin
                res_status_d = STAT_EMPTY;
              end else if (op_i.op == OP_REM_VAL) begin
                out_valid_d = 1'b0;
                ram_raddr   = '0;
                idx_d       = '0;
                state_d     = BK_SRCH_W;
              end else if (op_i.op == OP_REM_LAST || count_q == CW'(1)) begin
                count_d     = cnt_m1;
                res_count_d = cnt_m1;
              end else begin
                out_valid_d = 1'b0;
                ram_raddr   = AW'(1);
                idx_d       = '0;
                state_d     = BK_DN_W;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Read data holds the entry just below idx; move it up or drop the value in.
      BK_UP_W: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        if (shift_up) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_m1;
          if (idx_q == CW'(1)) begin
            state_d = BK_PUT;
          end else begin
            ram_raddr = idx_m2[AW-1:0];
          end
        end else begin
          ram_wdata    = val_q;
          count_d      = cnt_p1;
          out_valid_d  = 1'b1;
          res_status_d = STAT_OK;
          res_count_d  = cnt_p1;
          state_d      = BK_IDLE;
        end
      end

      BK_PUT: begin
        ram_we       = 1'b1;
        ram_waddr    = idx_q[AW-1:0];
        ram_wdata    = val_q;
        count_d      = cnt_p1;
        out_valid_d  = 1'b1;
        res_status_d = STAT_OK;
        res_count_d  = cnt_p1;
        state_d      = BK_IDLE;
      end

      // Read data holds entry idx; look for the first equal entry.
      BK_SRCH_W: begin
        if ($signed(ram_rdata) == val_q) begin
          if (idx_p1 == count_q) begin
            count_d      = cnt_m1;
            out_valid_d  = 1'b1;
            res_status_d = STAT_OK;
            res_count_d  = cnt_m1;
            state_d      = BK_IDLE;
          end else begin
            ram_raddr = idx_p1[AW-1:0];
            state_d   = BK_DN_W;
          end
        end else if (idx_p1 == count_q) begin
          out_valid_d  = 1'b1;
          res_status_d = STAT_NOTFOUND;
          res_count_d  = count_q;
          state_d      = BK_IDLE;
        end else begin
          ram_raddr = idx_p1[AW-1:0];
          idx_d     = idx_p1;
        end
      end

      // Read data holds entry idx+1; move it down into idx.
      BK_DN_W: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        if (idx_p2 == count_q) begin
          count_d      = cnt_m1;
          out_valid_d  = 1'b1;
          res_status_d = STAT_OK;
          res_count_d  = cnt_m1;
          state_d      = BK_IDLE;
        end else begin
          ram_raddr = idx_p2[AW-1:0];
          idx_d     = idx_p1;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
  end

  assign cnt_ext       = {{CntOutW{1'b0}}, res_count_q};
  assign out_valid_o   = out_valid_q;
  assign status_o      = res_status_q;
  assign entry_count_o = cnt_ext[CntOutW-1:0];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("entry count exceeds depth");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_IDLE) |-> !out_valid_q)
    else $error("result pending while an action is in progress");

  a_count_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $rose(out_valid_q))
    else $error("count changed without a result");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (res_count_q == count_q))
    else $error("reported count differs from stored count");
`endif

endmodule

// File: tb/sv/oale_result_checker.sv
// Result checker for the ordered array list engine: list prediction and result comparison.
module oale_result_checker
  import oale_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [ActW-1:0]         action_i,
  input  logic signed [ValW-1:0]  value_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [StatW-1:0]        status_i,
  input  logic [CntOutW-1:0]      entry_count_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct {
    status_e               status;
    logic [CntOutW-1:0]    count;
  } list_result_t;

  logic signed [ValW-1:0] list_mem [DEPTH];
  int unsigned            list_len = 0;
  list_result_t           expected_results [$];
  int                     fails = 0;

  // Applies one action to the shadow list and returns the status and count it yields.
  function automatic list_result_t apply_list_action(logic [ActW-1:0] act,
                                                     logic signed [ValW-1:0] val);
    list_result_t res;
    int unsigned  pos;
    bit           found;
    res.status = STAT_OK;
    case (act)
      ACT_INS_ORD, ACT_INS_BACK, ACT_INS_FRONT: begin
        if (list_len == DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          if (act == ACT_INS_BACK) begin
            list_mem[list_len] = val;
          end else if (act == ACT_INS_FRONT) begin
            for (pos = list_len; pos > 0; pos--) list_mem[pos] = list_mem[pos-1];
            list_mem[0] = val;
          end else begin
            // Scan from the back; larger entries move up one place.
            pos = list_len;
            while (pos > 0 && list_mem[pos-1] > val) begin
              list_mem[pos] = list_mem[pos-1];
              pos--;
            end
            list_mem[pos] = val;
          end
          list_len++;
        end
      end
      ACT_REM_FIRST, ACT_REM_LAST, ACT_REM_VAL: begin
        if (list_len == 0) begin
          res.status = STAT_EMPTY;
        end else if (act == ACT_REM_LAST) begin
          list_len--;
        end else begin
          pos   = 0;
          found = (act == ACT_REM_FIRST);
          while (!found && pos < list_len) begin
            if (list_mem[pos] == val) found = 1'b1;
            else pos++;
          end
          if (found) begin
            while (pos + 1 < list_len) begin
              list_mem[pos] = list_mem[pos+1];
              pos++;
            end
            list_len--;
          end else begin
            res.status = STAT_NOTFOUND;
          end
        end
      end
      default: ;
    endcase
    res.count = list_len[CntOutW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    list_result_t want;
    if (!rst_ni) begin
      list_len = 0;
      expected_results.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Results first: a result never belongs to a transaction taken in the same cycle.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d entry_count %0d", status_i, entry_count_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fails++;
          end
          if (entry_count_i !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, entry_count_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(apply_list_action(action_i, value_i));
      fail_count_o <= fails;
      pending_o    <= expected_results.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the ordered array list engine: stimulus, flow control and verdict.
//
// The top only produces traffic. A directed opening walks through removals on an
// empty list, the two unused action codes, inserts of the extreme values, an
// ordered insert into a list that is no longer sorted, a fill to the full depth,
// refused inserts of every kind, and removals that hit and miss. The random part
// then runs in short phases, each with its own insert/remove balance, so the list
// swings between empty and full many times. Half of the values come from a small pool
// that is refreshed per phase, which makes remove-by-value find matches often;
// the rest are small numbers, the two extremes, or fully random words.
// Both channels idle in random bursts; once, the result side holds off for a long
// stretch so the engine's queue fills and it stops taking transactions. The last
// part of the run has no idling at all. The checker instance predicts every
// result and counts mismatches; the top reads that count for the verdict.
module tb;
  import oale_pkg::*;

  localparam int DEPTH = 16;

  // Action codes with no function; the engine must answer them with an ok status.
  localparam logic [ActW-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ActW-1:0] ACT_SPARE_B = 3'd7;

  localparam int RandomItems = 1920;
  localparam int QuietItems  = 300;   // tail of the run without idling
  localparam int PhaseLen    = 25;
  localparam int HoldAtItem  = 600;   // where the long result-side hold begins
  localparam int HoldCycles  = 200;
  localparam int DrainLimit  = 5000;
  localparam int DrainCycles = 80;    // a few worst-case back-end actions

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic [ActW-1:0]         action_i    = '0;
  logic signed [ValW-1:0]  value_i     = '0;
  logic                    out_ready_i = 1'b0;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic [StatW-1:0]        status_o;
  logic [CntOutW-1:0]      entry_count_o;

  int                      fail_count;
  int                      pending;

  // Flags shared between the stimulus and the result-side process.
  bit                      quiet_tail = 1'b0;
  bit                      idle_on    = 1'b1;
  bit                      hold_req   = 1'b0;
  bit                      hold_done  = 1'b0;

  int                      ins_pct = 50;
  logic signed [ValW-1:0]  value_pool [8];

  ordered_array_list_engine_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  oale_result_checker #(
    .DEPTH(DEPTH)
  ) list_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .entry_count_i (entry_count_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one transaction and returns at the edge where it is taken. An optional idle
  // burst comes first; valid otherwise stays high straight into the next transaction.
  task automatic send_action(input logic [ActW-1:0] act, input logic signed [ValW-1:0] val);
    int gap;
    if (idle_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Inserts come in proportion to ins_pct; the unused codes show up now and then.
  function automatic logic [ActW-1:0] pick_action(int pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2)
      return ($urandom_range(0, 1) == 0) ? ACT_SPARE_A : ACT_SPARE_B;
    if (roll < pct) begin
      case ($urandom_range(0, 3))
        0, 1:    return ACT_INS_ORD;
        2:       return ACT_INS_BACK;
        default: return ACT_INS_FRONT;
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return ACT_REM_FIRST;
      1:       return ACT_REM_LAST;
      default: return ACT_REM_VAL;
    endcase
  endfunction

  // Pool values repeat, so ordered inserts see ties and remove-by-value finds matches.
  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return value_pool[$urandom_range(0, 7)];
      5, 6:          return $urandom_range(0, 20) - 10;
      7:             return ($urandom_range(0, 1) == 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default:       return $urandom;
    endcase
  endfunction

  // Result side: random ready bursts, one long hold, and steady ready in the tail.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (quiet_tail || $urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int pct_choices [5];
    pct_choices = '{85, 15, 50, 70, 30};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every removal on an empty list, then the two unused codes.
    send_action(ACT_REM_FIRST, 32'sd0);
    send_action(ACT_REM_LAST, 32'sd0);
    send_action(ACT_REM_VAL, 32'sd0);
    send_action(ACT_SPARE_A, 32'sd7);
    send_action(ACT_SPARE_B, -32'sd7);

    // Extreme values in order, then a large value forced to the front, so the
    // following ordered inserts run on a list that is not sorted any more.
    send_action(ACT_INS_ORD, 32'sd0);
    send_action(ACT_INS_ORD, 32'sh7fff_ffff);
    send_action(ACT_INS_ORD, 32'sh8000_0000);
    send_action(ACT_INS_ORD, -32'sd1);
    send_action(ACT_INS_FRONT, 32'sh7fff_ffff);
    send_action(ACT_INS_ORD, 32'sd5);
    send_action(ACT_INS_BACK, 32'sh8000_0000);
    send_action(ACT_INS_ORD, 32'sd1);

    // Fill up to the full depth with a mix of insert kinds.
    for (int k = 0; k < 8; k++)
      send_action(k % 3 == 0 ? ACT_INS_ORD : (k % 3 == 1 ? ACT_INS_BACK : ACT_INS_FRONT),
                  $urandom);

    // Refused inserts on the full list.
    send_action(ACT_INS_ORD, 32'sd3);
    send_action(ACT_INS_BACK, 32'sd3);
    send_action(ACT_INS_FRONT, 32'sd3);

    // A value that is absent, one in the middle, then both ends.
    send_action(ACT_REM_VAL, 32'sd12345);
    send_action(ACT_REM_VAL, -32'sd1);
    send_action(ACT_REM_FIRST, 32'sd0);
    send_action(ACT_REM_LAST, 32'sd0);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % PhaseLen == 0) begin
        ins_pct = pct_choices[$urandom_range(0, 4)];
        idle_on = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < 8; k++)
          value_pool[k] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 40) - 20;
      end
      if (n == RandomItems - QuietItems) quiet_tail = 1'b1;
      if (n == HoldAtItem) hold_req = 1'b1;
      send_action(pick_action(ins_pct), pick_value());
    end
    in_valid_i <= 1'b0;

    // Drain: wait for the outstanding results, then give the engine time to show
    // any stray result before the verdict.
    for (int w = 0; w < DrainLimit && pending != 0; w++) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
